>>> hdl/lprd_pkg.sv
// Package for the length-prefixed request deframer.
// Holds the word types, phase and code enums, and result builders.
// No dependencies.
`timescale 1ns / 1ps

package lprd_pkg;

    localparam int LPRD_IDX_W  = 12;
    localparam int LPRD_QDEPTH = 4;
    localparam int LPRD_QPTR_W = 2;
    localparam int LPRD_QCNT_W = 3;

    typedef enum logic [2:0] {
        PH_LEN   = 3'd0,
        PH_COUNT = 3'd1,
        PH_SLEN  = 3'd2,
        PH_DATA  = 3'd3,
        PH_DROP  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_TOO_LONG = 3'd2,
        ERR_TOO_MANY = 3'd3,
        ERR_PARTIAL  = 3'd4,
        ERR_OVERRUN  = 3'd5,
        ERR_TRAILING = 3'd6
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            payload;
        logic [LPRD_IDX_W-1:0] string_index;
        logic                  first_of_string;
        logic                  end_of_string;
        t_err                  error_code;
        logic                  last;
    } t_result;

    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_event;

    function automatic t_result mk_reject(input t_err code);
        t_result r;
        r = '0;
        r.kind = KIND_REJECT;
        r.error_code = code;
        return r;
    endfunction

    function automatic t_result mk_accept();
        t_result r;
        r = '0;
        r.kind = KIND_ACCEPT;
        return r;
    endfunction

    function automatic t_result mk_empty(input logic [LPRD_IDX_W-1:0] idx);
        t_result r;
        r = '0;
        r.kind = KIND_EMPTY;
        r.string_index = idx;
        return r;
    endfunction

    function automatic t_result mk_data(input logic [7:0] b,
                                        input logic [LPRD_IDX_W-1:0] idx,
                                        input logic first, input logic fin);
        t_result r;
        r = '0;
        r.kind = KIND_DATA;
        r.payload = b;
        r.string_index = idx;
        r.first_of_string = first;
        r.end_of_string = fin;
        return r;
    endfunction

endpackage

>>> hdl/lprd_front.sv
// Front end: accepts stream words, tracks frame structure, builds events.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_front #(
    parameter int MAX_BODY_BYTES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  lprd_pkg::t_in_item i_item,
    output logic              o_ev_valid,
    output lprd_pkg::t_event  o_ev
);
    import lprd_pkg::*;

    localparam int BW = $clog2(MAX_BODY_BYTES + 1);

    typedef struct packed {
        logic    emit;
        t_result rec;
        t_phase  nxt;
    } t_after;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_cnt, n_cnt;
    logic [31:0]           r_acc, n_acc;
    logic [BW-1:0]         r_body, n_body;
    logic [BW-1:0]         r_strings, n_strings;
    logic [BW-1:0]         r_sleft, n_sleft;
    logic [LPRD_IDX_W-1:0] r_cur, n_cur;

    logic [31:0]   word;
    logic          word_done;
    logic [BW-1:0] body_dec;
    logic [BW-1:0] strings_dec;
    t_after        aft;
    t_event        ev;
    logic          ev_valid;

    function automatic t_after after_string(input logic [BW-1:0] strings,
                                            input logic [BW-1:0] body);
        t_after a;
        a = '0;
        if (strings == '0) begin
            a.emit = 1'b1;
            if (body == '0) begin
                a.rec = mk_accept();
                a.nxt = PH_LEN;
            end else begin
                a.rec = mk_reject(ERR_TRAILING);
                a.nxt = PH_DROP;
            end
        end else if (body < BW'(4)) begin
            a.emit = 1'b1;
            a.rec = mk_reject(ERR_PARTIAL);
            a.nxt = PH_DROP;
        end else begin
            a.nxt = PH_SLEN;
        end
        return a;
    endfunction

    assign word        = r_acc | (32'(i_item.data_byte) << {r_cnt, 3'b000});
    assign word_done   = (r_cnt == 2'd3);
    assign body_dec    = r_body - BW'(1);
    assign strings_dec = r_strings - BW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_body    <= '0;
            r_strings <= '0;
            r_sleft   <= '0;
            r_cur     <= '0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_body    <= n_body;
            r_strings <= n_strings;
            r_sleft   <= n_sleft;
            r_cur     <= n_cur;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_body    = r_body;
        n_strings = r_strings;
        n_sleft   = r_sleft;
        n_cur     = r_cur;
        ev        = '0;
        ev_valid  = 1'b0;
        aft       = '0;

        if (i_item.restart) begin
            n_phase   = PH_LEN;
            n_cnt     = '0;
            n_acc     = '0;
            n_body    = '0;
            n_strings = '0;
            n_sleft   = '0;
            n_cur     = '0;
        end else begin
            unique case (r_phase)
                PH_LEN: begin
                    n_acc = word;
                    n_cnt = r_cnt + 2'd1;
                    if (word_done) begin
                        if (word > 32'(MAX_BODY_BYTES)) begin
                            ev.res0  = mk_reject(ERR_TOO_LONG);
                            ev_valid = 1'b1;
                            n_phase  = PH_DROP;
                        end else if (word < 32'd4) begin
                            ev.res0  = mk_reject(ERR_SHORT);
                            ev_valid = 1'b1;
                            n_phase  = PH_DROP;
                        end else begin
                            n_body  = word[BW-1:0];
                            n_cnt   = '0;
                            n_acc   = '0;
                            n_phase = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    n_body = body_dec;
                    n_acc  = word;
                    n_cnt  = r_cnt + 2'd1;
                    if (word_done) begin
                        if (word > 32'(MAX_BODY_BYTES)) begin
                            ev.res0  = mk_reject(ERR_TOO_MANY);
                            ev_valid = 1'b1;
                            n_phase  = PH_DROP;
                        end else begin
                            n_strings = word[BW-1:0];
                            n_cur     = '0;
                            aft       = after_string(word[BW-1:0], body_dec);
                            ev.res0   = aft.rec;
                            ev_valid  = aft.emit;
                            n_phase   = aft.nxt;
                            n_cnt     = '0;
                            n_acc     = '0;
                        end
                    end
                end
                PH_SLEN: begin
                    n_body = body_dec;
                    n_acc  = word;
                    n_cnt  = r_cnt + 2'd1;
                    if (word_done) begin
                        if (word > 32'(body_dec)) begin
                            ev.res0  = mk_reject(ERR_OVERRUN);
                            ev_valid = 1'b1;
                            n_phase  = PH_DROP;
                        end else if (word == '0) begin
                            ev.res0   = mk_empty(r_cur);
                            ev_valid  = 1'b1;
                            n_strings = strings_dec;
                            n_cur     = r_cur + LPRD_IDX_W'(1);
                            aft       = after_string(strings_dec, body_dec);
                            ev.res1   = aft.rec;
                            ev.two    = aft.emit;
                            n_phase   = aft.nxt;
                            n_cnt     = '0;
                            n_acc     = '0;
                        end else begin
                            n_sleft = word[BW-1:0];
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    ev.res0  = mk_data(i_item.data_byte, r_cur,
                                       32'(r_sleft) == r_acc, r_sleft == BW'(1));
                    ev_valid = 1'b1;
                    n_body   = body_dec;
                    n_sleft  = r_sleft - BW'(1);
                    if (r_sleft == BW'(1)) begin
                        n_strings = strings_dec;
                        n_cur     = r_cur + LPRD_IDX_W'(1);
                        aft       = after_string(strings_dec, body_dec);
                        ev.res1   = aft.rec;
                        ev.two    = aft.emit;
                        n_phase   = aft.nxt;
                        n_cnt     = '0;
                        n_acc     = '0;
                    end
                end
                default: begin
                    n_phase = PH_DROP;
                end
            endcase
        end

        if (ev.two) begin
            ev.res1.last = 1'b1;
        end else begin
            ev.res0.last = 1'b1;
        end
    end

    assign o_ev_valid = i_take && ev_valid;
    assign o_ev       = ev;

endmodule

>>> hdl/lprd_queue.sv
// Short event queue between the front end and the result serializer.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  lprd_pkg::t_event i_wdata,
    input  logic             i_rd,
    output lprd_pkg::t_event o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    import lprd_pkg::*;

    t_event                 r_mem [LPRD_QDEPTH];
    logic [LPRD_QPTR_W-1:0] r_wptr, r_rptr;
    logic [LPRD_QCNT_W-1:0] r_count;
    logic                   wr_ok, rd_ok;

    assign o_full  = (r_count == LPRD_QCNT_W'(LPRD_QDEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= r_wptr + LPRD_QPTR_W'(1);
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + LPRD_QPTR_W'(1);
            end
            r_count <= r_count + LPRD_QCNT_W'(wr_ok) - LPRD_QCNT_W'(rd_ok);
        end
    end

endmodule

>>> hdl/lprd_back.sv
// Back end: splits queued events into single results behind an output register.
// Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  lprd_pkg::t_event  i_q_data,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output lprd_pkg::t_result o_result
);
    import lprd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_out, n_out;
    logic    r_second_valid, n_second_valid;
    t_result r_second, n_second;
    logic    slot_free;

    assign slot_free = !r_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_second_valid <= 1'b0;
        end else begin
            r_valid        <= n_valid;
            r_second_valid <= n_second_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_second <= n_second;
    end

    always_comb begin
        n_valid        = r_valid;
        n_out          = r_out;
        n_second_valid = r_second_valid;
        n_second       = r_second;
        o_q_rd         = 1'b0;
        if (slot_free) begin
            if (r_second_valid) begin
                n_out          = r_second;
                n_valid        = 1'b1;
                n_second_valid = 1'b0;
            end else if (!i_q_empty) begin
                o_q_rd         = 1'b1;
                n_out          = i_q_data.res0;
                n_valid        = 1'b1;
                n_second       = i_q_data.res1;
                n_second_valid = i_q_data.two;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    assign o_empty  = !r_valid;
    assign o_result = r_out;

    a_second_behind_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second_valid |-> r_valid)
        else $error("second result held without a first");

    a_first_of_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second_valid |-> (!r_out.last && r_second.last))
        else $error("last mark misplaced in result pair");

    a_data_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.kind == KIND_DATA) |-> (r_out.error_code == ERR_NONE))
        else $error("data result carries an error code");

    a_reject_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.kind == KIND_REJECT) |->
        (r_out.error_code != ERR_NONE && r_out.payload == 8'd0))
        else $error("reject result malformed");

endmodule

>>> hdl/length_prefixed_request_deframer.sv
// Top level of the length-prefixed request deframer: front end, event queue, back end.
// Depends on lprd_pkg, lprd_front, lprd_queue, lprd_back.
//
//  channel | handshake            | word
//  input   | push / full          | i_item   (data_byte, restart)
//  result  | pop / empty          | o_result (kind, payload, string_index, first_of_string,
//          |                      |           end_of_string, error_code, last)
//
// One byte is taken per cycle unless full; the front end updates its counters that cycle.
// Each byte yields zero, one or two results; the back end hands out one result per cycle,
// so a stalled pop fills the four-entry event queue and then raises full.
// The first result of a byte passes the event queue, then the back end's output register.
// Reset is synchronous, active low, and empties the queue and output register.
`timescale 1ns / 1ps

module length_prefixed_request_deframer #(
    parameter int MAX_BODY_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  lprd_pkg::t_in_item i_item,
    output logic               empty,
    input  logic               pop,
    output lprd_pkg::t_result  o_result
);
    import lprd_pkg::*;

    logic   take;
    logic   ev_valid;
    t_event ev;
    logic   q_full, q_empty, q_rd;
    t_event q_data;

    assign full = q_full;
    assign take = push && !q_full;

    lprd_front #(
        .MAX_BODY_BYTES (MAX_BODY_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_item),
        .o_ev_valid (ev_valid),
        .o_ev       (ev)
    );

    lprd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ev_valid),
        .i_wdata (ev),
        .i_rd    (q_rd),
        .o_rdata (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lprd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

>>> sim/length_prefixed_request_deframer_test.sv
// Self-checking testbench for length_prefixed_request_deframer: directed and random byte
// streams, an in-bench parser predicting every result word, random idling on both sides.
// Depends on lprd_pkg and length_prefixed_request_deframer.
`timescale 1ns / 1ps

module length_prefixed_request_deframer_test;

    import lprd_pkg::*;

    localparam int unsigned MAX_BODY   = 4096;
    localparam logic [31:0] BODY_LIMIT = MAX_BODY;
    localparam int          N_RANDOM   = 1550;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_stim;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_in_item i_item  = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    t_stim   stream_q[$];
    t_result due_results[$];
    t_result got_results[$];
    t_result step_res[$];
    bit      failed = 1'b0;
    int unsigned cyc = 0;
    int unsigned words_taken = 0;
    int unsigned hold_left = 0;

    // parser state
    t_phase                ph;
    logic [1:0]            wcnt;
    logic [31:0]           wacc;
    logic [12:0]           body_left;
    logic [12:0]           strings_left;
    logic [12:0]           chars_left;
    logic [LPRD_IDX_W-1:0] str_idx;

    length_prefixed_request_deframer #(
        .MAX_BODY_BYTES(MAX_BODY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic bit idle_now();
        return (cyc < 2500 || cyc >= 4000) && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic void clear_parser();
        ph           = PH_LEN;
        wcnt         = '0;
        wacc         = '0;
        body_left    = '0;
        strings_left = '0;
        chars_left   = '0;
        str_idx      = '0;
    endfunction

    function automatic void add_result(input t_kind k, input logic [7:0] b,
                                       input logic first, input logic fin, input t_err code);
        t_result r;
        r                 = '0;
        r.kind            = k;
        r.payload         = b;
        r.string_index    = (k == KIND_DATA || k == KIND_EMPTY) ? str_idx : '0;
        r.first_of_string = first;
        r.end_of_string   = fin;
        r.error_code      = code;
        step_res.insert(step_res.size(), r);
    endfunction

    function automatic void start_word(input t_phase next_ph);
        wcnt = '0;
        wacc = '0;
        ph   = next_ph;
    endfunction

    function automatic void reject_frame(input t_err code);
        add_result(KIND_REJECT, 8'h00, 1'b0, 1'b0, code);
        ph = PH_DROP;
    endfunction

    function automatic bit shift_in(input logic [7:0] b);
        wacc = wacc | ({24'h0, b} << (8 * wcnt));
        wcnt = wcnt + 2'd1;
        return wcnt == 2'd0;
    endfunction

    function automatic void close_string();
        if (strings_left == 0) begin
            if (body_left == 0) begin
                add_result(KIND_ACCEPT, 8'h00, 1'b0, 1'b0, ERR_NONE);
                start_word(PH_LEN);
            end else begin
                reject_frame(ERR_TRAILING);
            end
        end else if (body_left < 13'd4) begin
            reject_frame(ERR_PARTIAL);
        end else begin
            start_word(PH_SLEN);
        end
    endfunction

    function automatic void parse_byte(input t_in_item it);
        logic [7:0] b;
        logic       first;
        logic       fin;
        b = it.data_byte;
        step_res.delete();
        if (it.restart) begin
            clear_parser();
        end else begin
            case (ph)
                PH_LEN: begin
                    if (shift_in(b)) begin
                        if (wacc > BODY_LIMIT) begin
                            reject_frame(ERR_TOO_LONG);
                        end else if (wacc < 32'd4) begin
                            reject_frame(ERR_SHORT);
                        end else begin
                            body_left = wacc[12:0];
                            start_word(PH_COUNT);
                        end
                    end
                end
                PH_COUNT: begin
                    body_left = body_left - 13'd1;
                    if (shift_in(b)) begin
                        if (wacc > BODY_LIMIT) begin
                            reject_frame(ERR_TOO_MANY);
                        end else begin
                            strings_left = wacc[12:0];
                            str_idx      = '0;
                            close_string();
                        end
                    end
                end
                PH_SLEN: begin
                    body_left = body_left - 13'd1;
                    if (shift_in(b)) begin
                        if (wacc > {19'h0, body_left}) begin
                            reject_frame(ERR_OVERRUN);
                        end else if (wacc == 32'd0) begin
                            add_result(KIND_EMPTY, 8'h00, 1'b0, 1'b0, ERR_NONE);
                            strings_left = strings_left - 13'd1;
                            str_idx      = str_idx + 1'b1;
                            close_string();
                        end else begin
                            chars_left = wacc[12:0];
                            ph         = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    first = ({19'h0, chars_left} == wacc);
                    fin   = (chars_left == 13'd1);
                    add_result(KIND_DATA, b, first, fin, ERR_NONE);
                    body_left  = body_left - 13'd1;
                    chars_left = chars_left - 13'd1;
                    if (fin) begin
                        strings_left = strings_left - 13'd1;
                        str_idx      = str_idx + 1'b1;
                        close_string();
                    end
                end
                default: begin
                end
            endcase
        end
        if (step_res.size() != 0) begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
        foreach (step_res[i]) begin
            due_results.insert(due_results.size(), step_res[i]);
        end
    endfunction

    task automatic compare_result(input t_result want, input t_result got);
        if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            failed = 1'b1;
        end
        if (got.payload !== want.payload) begin
            $display("%0t: payload expected %0h actual %0h", $time, want.payload, got.payload);
            failed = 1'b1;
        end
        if (got.string_index !== want.string_index) begin
            $display("%0t: string_index expected %0d actual %0d", $time,
                     want.string_index, got.string_index);
            failed = 1'b1;
        end
        if (got.first_of_string !== want.first_of_string) begin
            $display("%0t: first_of_string expected %0b actual %0b", $time,
                     want.first_of_string, got.first_of_string);
            failed = 1'b1;
        end
        if (got.end_of_string !== want.end_of_string) begin
            $display("%0t: end_of_string expected %0b actual %0b", $time,
                     want.end_of_string, got.end_of_string);
            failed = 1'b1;
        end
        if (got.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, got.error_code);
            failed = 1'b1;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            failed = 1'b1;
        end
    endtask

    task automatic put_item(input logic [7:0] b, input logic rs);
        t_stim s;
        s.item.data_byte = b;
        s.item.restart   = rs;
        s.drain          = 1'b0;
        stream_q.insert(stream_q.size(), s);
    endtask

    task automatic put_restart();
        put_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            put_item(w[8 * i +: 8], 1'b0);
        end
    endtask

    task automatic put_frame(input int n_str, input int max_len, input int len_skew,
                             input int cnt_skew);
        int lens[$];
        int total;
        total = 4;
        for (int s = 0; s < n_str; s++) begin
            lens.insert(lens.size(), $urandom_range(0, max_len));
            total += 4 + lens[s];
        end
        put_word(total + len_skew);
        put_word(n_str + cnt_skew);
        foreach (lens[s]) begin
            put_word(lens[s]);
            repeat (lens[s]) put_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push   <= 1'b0;
            i_item <= '0;
            clear_parser();
        end else begin
            if (push && !full) begin
                parse_byte(i_item);
                void'(stream_q.pop_front());
            end
            if (!(push && full)) begin
                if (stream_q.size() == 0 || (stream_q[0].drain && due_results.size() != 0)
                        || idle_now()) begin
                    push <= 1'b0;
                end else begin
                    stream_q[0].drain = 1'b0;
                    push   <= 1'b1;
                    i_item <= stream_q[0].item;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_results.insert(got_results.size(), o_result);
                words_taken++;
                if (words_taken == 300) begin
                    hold_left = 400;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= !idle_now();
            end
        end
    end

    always @(negedge i_clk) begin
        if (got_results.size() != 0) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result word kind %0d payload %0h error_code %0d",
                         $time, got_results[0].kind, got_results[0].payload,
                         got_results[0].error_code);
                failed = 1'b1;
                got_results.delete();
            end else begin
                compare_result(due_results.pop_front(), got_results.pop_front());
            end
        end
    end

    initial begin
        int mark;
        int pick;
        // accepted frame with no strings
        put_frame(0, 0, 0, 0);
        // short body, then drop a byte
        put_word(32'd3);
        put_item(8'hA5, 1'b0);
        put_restart();
        // body too long, all ones
        put_word(BODY_LIMIT + 1);
        put_restart();
        put_word(32'hFFFF_FFFF);
        put_restart();
        // too many strings
        put_word(32'd8);
        put_word(BODY_LIMIT + 1);
        put_restart();
        // partial length word
        put_frame(1, 0, -2, 0);
        put_restart();
        // string past body
        put_word(32'd8);
        put_word(32'd1);
        put_word(32'd1);
        put_restart();
        // trailing bytes
        put_frame(0, 0, 1, 0);
        put_restart();
        // empty string closes the frame
        put_frame(1, 0, 0, 0);
        // two strings with data at the byte extremes
        put_word(32'd15);
        put_word(32'd2);
        put_word(32'd1);
        put_item(8'hFF, 1'b0);
        put_word(32'd2);
        put_item(8'h00, 1'b0);
        put_item(8'h80, 1'b0);
        // largest body and string count pass the header checks
        put_word(BODY_LIMIT);
        put_word(BODY_LIMIT);
        put_item(8'h01, 1'b0);
        put_restart();

        mark = stream_q.size();
        while (stream_q.size() < mark + N_RANDOM) begin
            if ($urandom_range(0, 99) < 6) begin
                put_restart();
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 19) == 0) begin
                    put_frame($urandom_range(5, 30), 24, 0, 0);
                end else begin
                    put_frame($urandom_range(0, 4), $urandom_range(0, 6), 0, 0);
                end
            end else if (pick < 78) begin
                put_frame($urandom_range(0, 4), $urandom_range(0, 6),
                          int'($urandom_range(0, 12)) - 6, int'($urandom_range(0, 2)) - 1);
                put_restart();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 12)) put_item(8'($urandom_range(0, 255)), 1'b0);
                put_restart();
            end else begin
                case ($urandom_range(0, 3))
                    0: put_word($urandom);
                    1: put_word($urandom_range(0, 3));
                    2: put_word($urandom_range(MAX_BODY + 1, 70000));
                    default: begin
                        put_word($urandom_range(8, 64));
                        put_word($urandom | 32'h0000_2000);
                    end
                endcase
                put_restart();
            end
        end
        stream_q[mark].drain       = 1'b1;
        stream_q[mark + 700].drain = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_q.size() != 0) @(posedge i_clk);
        while (due_results.size() != 0 || got_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d expected result words never arrived, next kind %0d",
                     $time, due_results.size(), due_results[0].kind);
            failed = 1'b1;
        end
        if (!failed) begin
            $display("[length_prefixed_request_deframer] OK");
        end else begin
            $display("[length_prefixed_request_deframer] ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[length_prefixed_request_deframer] ERROR");
        $finish;
    end

endmodule

>>> length_prefixed_request_deframer.f
hdl/lprd_pkg.sv
hdl/lprd_front.sv
hdl/lprd_queue.sv
hdl/lprd_back.sv
hdl/length_prefixed_request_deframer.sv
sim/length_prefixed_request_deframer_test.sv
